[rtl/format_spec_parser_macros.svh]
// Assertion macros for the format spec parser checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef FORMAT_SPEC_PARSER_MACROS_SVH
`define FORMAT_SPEC_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fsp_pkg.sv]
// Shared constants and types for the format spec parser.
// No dependencies; used by fsp_step and the top level.
`default_nettype none

package fsp_pkg;

  localparam int VALUE_BITS_DEF = 31;

  // Parse phases
  localparam logic [2:0] PH_FLAGS = 3'd0;
  localparam logic [2:0] PH_WIDTH = 3'd1;
  localparam logic [2:0] PH_WDIG  = 3'd2;
  localparam logic [2:0] PH_PREC  = 3'd3;
  localparam logic [2:0] PH_PDIG  = 3'd4;
  localparam logic [2:0] PH_AFTER = 3'd5;
  localparam logic [2:0] PH_LEN   = 3'd6;

  // Flag bit positions
  localparam int FB_ALT   = 0;
  localparam int FB_ZERO  = 1;
  localparam int FB_LEFT  = 2;
  localparam int FB_PLUS  = 3;
  localparam int FB_SPACE = 4;

  // Length codes
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_HH   = 3'd1;
  localparam logic [2:0] LEN_H    = 3'd2;
  localparam logic [2:0] LEN_LL   = 3'd3;
  localparam logic [2:0] LEN_L    = 3'd4;
  localparam logic [2:0] LEN_J    = 3'd5;
  localparam logic [2:0] LEN_Z    = 3'd6;
  localparam logic [2:0] LEN_BIGL = 3'd7;

  // Pending single length letter
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_H    = 2'd1;
  localparam logic [1:0] PEND_L    = 2'd2;

  // Characters
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_J     = 8'h6A;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_BIGL  = 8'h4C;

  // Narrow parse state (value registers travel separately, width set by parameter)
  typedef struct packed {
    logic [2:0] phase;
    logic [4:0] flags;
    logic [2:0] length;
    logic [1:0] pending;
  } fsp_ctl_t;

  // One parsed spec
  typedef struct packed {
    logic [7:0]         conversion_char;
    logic               flag_alt;
    logic               flag_zero;
    logic               flag_left;
    logic               flag_plus;
    logic               flag_space;
    logic [30:0]        field_width;
    logic signed [31:0] precision;
    logic [2:0]         length_code;
  } fsp_result_t;

  localparam fsp_ctl_t CTL_RESET = '{phase: PH_FLAGS, flags: 5'd0,
                                     length: LEN_NONE, pending: PEND_NONE};

endpackage

`default_nettype wire

[rtl/fsp_if.sv]
// Valid/ready channel interfaces for spec characters and parsed specs.
// Standalone; no package dependency.
`default_nettype none

interface fsp_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         character;
  logic signed [31:0] star_value;

  modport source (output valid, output character, output star_value, input ready);
  modport sink   (input valid, input character, input star_value, output ready);
endinterface

interface fsp_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         conversion_char;
  logic               flag_alt;
  logic               flag_zero;
  logic               flag_left;
  logic               flag_plus;
  logic               flag_space;
  logic [30:0]        field_width;
  logic signed [31:0] precision;
  logic [2:0]         length_code;

  modport source (output valid, output conversion_char, output flag_alt,
                  output flag_zero, output flag_left, output flag_plus,
                  output flag_space, output field_width, output precision,
                  output length_code, input ready);
  modport sink   (input valid, input conversion_char, input flag_alt,
                  input flag_zero, input flag_left, input flag_plus,
                  input flag_space, input field_width, input precision,
                  input length_code, output ready);
endinterface

`default_nettype wire

[rtl/fsp_step.sv]
// Next-state and result logic for one spec character.
// Depends on fsp_pkg.
`default_nettype none

module fsp_step
  import fsp_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic [7:0]            character,
  input  wire logic signed [31:0]    star_value,
  input  wire fsp_ctl_t              ctl,
  input  wire logic [VALUE_BITS-1:0] wv,
  input  wire logic [VALUE_BITS-1:0] pm,
  input  wire logic                  pn,
  output fsp_ctl_t                   ctl_nxt,
  output logic [VALUE_BITS-1:0]      wv_nxt,
  output logic [VALUE_BITS-1:0]      pm_nxt,
  output logic                       pn_nxt,
  output logic                       emit,
  output fsp_result_t                res
);

  localparam logic [VALUE_BITS-1:0] MAXV  = {VALUE_BITS{1'b1}};
  localparam logic [31:0]           MAX32 = 32'(MAXV);

  // Saturating v*10+d
  function automatic logic [VALUE_BITS-1:0] dec_acc(input logic [VALUE_BITS-1:0] v,
                                                    input logic [3:0] d);
    logic [VALUE_BITS+3:0] ext;
    logic [VALUE_BITS+3:0] r;
    ext = (VALUE_BITS+4)'(v);
    r   = (ext << 3) + (ext << 1) + (VALUE_BITS+4)'(d);
    return (r > (VALUE_BITS+4)'(MAXV)) ? MAXV : r[VALUE_BITS-1:0];
  endfunction

  logic                  is_dig;
  logic [3:0]            dval;
  logic                  s_neg;
  logic [31:0]           s_mag;
  logic [VALUE_BITS-1:0] s_sat;
  logic [VALUE_BITS-1:0] w_acc;
  logic [VALUE_BITS-1:0] p_acc;
  logic [VALUE_BITS-1:0] p_cur;

  logic [2:0]            ph;
  logic [4:0]            fl;
  logic [2:0]            lv;
  logic [1:0]            pl;
  logic [VALUE_BITS-1:0] w;
  logic [VALUE_BITS-1:0] p;
  logic                  pneg;
  logic                  done;

  assign is_dig = (character >= CH_ZERO) && (character <= CH_NINE);
  assign dval   = character[3:0];
  assign s_neg  = star_value[31];
  assign s_mag  = s_neg ? (~star_value + 32'd1) : star_value;
  assign s_sat  = (s_mag > MAX32) ? MAXV : s_mag[VALUE_BITS-1:0];
  assign w_acc  = dec_acc(wv, dval);
  assign p_cur  = pn ? '0 : pm;
  assign p_acc  = dec_acc(p_cur, dval);

  always_comb begin
    ph   = ctl.phase;
    fl   = ctl.flags;
    lv   = ctl.length;
    pl   = ctl.pending;
    w    = wv;
    p    = pm;
    pneg = pn;
    done = 1'b0;
    emit = 1'b0;

    if (ph == PH_FLAGS) begin
      priority if (character == CH_HASH) begin
        fl[FB_ALT] = 1'b1;
        done = 1'b1;
      end else if (character == CH_ZERO) begin
        fl[FB_ZERO] = 1'b1;
        done = 1'b1;
      end else if (character == CH_MINUS) begin
        fl[FB_LEFT] = 1'b1;
        done = 1'b1;
      end else if (character == CH_PLUS) begin
        fl[FB_PLUS] = 1'b1;
        done = 1'b1;
      end else if (character == CH_SPACE) begin
        fl[FB_SPACE] = 1'b1;
        done = 1'b1;
      end else begin
        if (fl[FB_LEFT]) fl[FB_ZERO] = 1'b0;
        if (fl[FB_PLUS]) fl[FB_SPACE] = 1'b0;
        ph = PH_WIDTH;
      end
    end

    if (!done && ph == PH_WIDTH) begin
      priority if (character >= CH_ONE && character <= CH_NINE) begin
        w    = VALUE_BITS'(dval);
        ph   = PH_WDIG;
        done = 1'b1;
      end else if (character == CH_STAR) begin
        if (s_neg) fl[FB_LEFT] = 1'b1;
        w    = s_sat;
        ph   = PH_AFTER;
        done = 1'b1;
      end else begin
        ph = PH_AFTER;
      end
    end

    if (!done && ph == PH_WDIG) begin
      if (is_dig) begin
        w    = w_acc;
        done = 1'b1;
      end else begin
        ph = PH_AFTER;
      end
    end

    if (!done && ph == PH_PREC) begin
      priority if (character == CH_STAR) begin
        // star zero reads as explicit zero, negative star as none
        if (star_value == 32'sd0) begin
          pneg = 1'b1;
          p    = '0;
        end else if (s_neg) begin
          pneg = 1'b0;
          p    = '0;
        end else begin
          pneg = 1'b0;
          p    = s_sat;
        end
        ph   = PH_AFTER;
        done = 1'b1;
      end else if (is_dig) begin
        ph = PH_PDIG;
      end else begin
        ph = PH_AFTER;
      end
    end

    if (!done && ph == PH_PDIG) begin
      if (is_dig) begin
        pneg = (p_acc == '0);
        p    = p_acc;
        done = 1'b1;
      end else begin
        ph = PH_AFTER;
      end
    end

    if (!done && ph == PH_AFTER) begin
      if (character == CH_DOT) begin
        pneg = 1'b1;
        p    = '0;
        ph   = PH_PREC;
        done = 1'b1;
      end else begin
        ph = PH_LEN;
      end
    end

    if (!done && ph == PH_LEN) begin
      done = 1'b1;
      priority if (character == CH_H) begin
        if (pl == PEND_H) begin
          lv = LEN_HH;
          pl = PEND_NONE;
        end else begin
          lv = LEN_H;
          pl = PEND_H;
        end
      end else if (character == CH_L) begin
        if (pl == PEND_L) begin
          lv = LEN_LL;
          pl = PEND_NONE;
        end else begin
          lv = LEN_L;
          pl = PEND_L;
        end
      end else if (character == CH_J) begin
        lv = LEN_J;
        pl = PEND_NONE;
      end else if (character == CH_Z) begin
        lv = LEN_Z;
        pl = PEND_NONE;
      end else if (character == CH_BIGL) begin
        lv = LEN_BIGL;
        pl = PEND_NONE;
      end else begin
        done = 1'b0;
      end
    end

    emit = !done;

    res.conversion_char = character;
    res.flag_alt        = fl[FB_ALT];
    res.flag_zero       = fl[FB_ZERO];
    res.flag_left       = fl[FB_LEFT];
    res.flag_plus       = fl[FB_PLUS];
    res.flag_space      = fl[FB_SPACE];
    res.field_width     = 31'(w);
    res.precision       = pneg ? '1 : 32'(p);
    res.length_code     = lv;

    if (emit) begin
      ctl_nxt = CTL_RESET;
      wv_nxt  = '0;
      pm_nxt  = '0;
      pn_nxt  = 1'b0;
    end else begin
      ctl_nxt.phase   = ph;
      ctl_nxt.flags   = fl;
      ctl_nxt.length  = lv;
      ctl_nxt.pending = pl;
      wv_nxt          = w;
      pm_nxt          = p;
      pn_nxt          = pneg;
    end
  end

endmodule

`default_nettype wire

[rtl/format_spec_parser.sv]
// A terminator waits in the input register while the previous spec is still unread.
// Throughput: otherwise one character per cycle; the per-character parse step is one
//   combinational pass between the input register and the parse/result registers.
// A finished spec waits in the result register while the next characters are taken.
// Reset (rst_n low, synchronous): both channels empty, parser in the flags phase.
`default_nettype none

module format_spec_parser
  import fsp_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  fsp_in_if.sink    in_req,
  fsp_out_if.source out_rsp
);

  // Input register: one spec character and its star argument
  logic               in_v_r;
  logic [7:0]         in_char_r;
  logic signed [31:0] in_star_r;

  // Parse state. Precision is kept as a magnitude plus an "explicit zero" bit
  // so the value registers stay VALUE_BITS wide.
  fsp_ctl_t              ctl_r;
  logic [VALUE_BITS-1:0] wv_r;
  logic [VALUE_BITS-1:0] pm_r;
  logic                  pn_r;

  // Result register
  logic        out_v_r;
  fsp_result_t out_r;

  // Step outputs
  fsp_ctl_t              ctl_nxt;
  logic [VALUE_BITS-1:0] wv_nxt;
  logic [VALUE_BITS-1:0] pm_nxt;
  logic                  pn_nxt;
  logic                  emit;
  fsp_result_t           res;

  logic adv;
  logic in_fire;

  fsp_step #(
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .character (in_char_r),
    .star_value(in_star_r),
    .ctl       (ctl_r),
    .wv        (wv_r),
    .pm        (pm_r),
    .pn        (pn_r),
    .ctl_nxt   (ctl_nxt),
    .wv_nxt    (wv_nxt),
    .pm_nxt    (pm_nxt),
    .pn_nxt    (pn_nxt),
    .emit      (emit),
    .res       (res)
  );

  // The held character steps unless it ends a spec while the previous spec
  // still sits unread in the result register. Characters that end nothing
  // always step, so a stalled sink only blocks at a terminator.
  assign adv     = in_v_r && !(emit && out_v_r && !out_rsp.ready);
  assign in_fire = in_req.valid && in_req.ready;

  assign in_req.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      ctl_r   <= CTL_RESET;
      wv_r    <= '0;
      pm_r    <= '0;
      pn_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end

      if (adv) begin
        ctl_r <= ctl_nxt;
        wv_r  <= wv_nxt;
        pm_r  <= pm_nxt;
        pn_r  <= pn_nxt;
      end

      if (adv && emit) begin
        out_v_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_char_r <= in_req.character;
      in_star_r <= in_req.star_value;
    end
    if (adv && emit) begin
      out_r <= res;
    end
  end

  assign out_rsp.valid           = out_v_r;
  assign out_rsp.conversion_char = out_r.conversion_char;
  assign out_rsp.flag_alt        = out_r.flag_alt;
  assign out_rsp.flag_zero       = out_r.flag_zero;
  assign out_rsp.flag_left       = out_r.flag_left;
  assign out_rsp.flag_plus       = out_r.flag_plus;
  assign out_rsp.flag_space      = out_r.flag_space;
  assign out_rsp.field_width     = out_r.field_width;
  assign out_rsp.precision       = out_r.precision;
  assign out_rsp.length_code     = out_r.length_code;

endmodule

`default_nettype wire

[rtl/fsp_checker.sv]
// Port-level checks for format_spec_parser, bound to the top level.
// Depends on format_spec_parser_macros.svh.
`default_nettype none

`include "format_spec_parser_macros.svh"

module fsp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               flag_plus,
  input wire logic               flag_space,
  input wire logic signed [31:0] precision
);

  `FSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "spec dropped while stalled")
  `FSP_ASSERT_SAME(a_prec_range, out_valid, !precision[31] || precision == '1, "bad precision")
  `FSP_ASSERT_SAME(a_plus_space, out_valid, !(flag_plus && flag_space), "space not cleared")
  `FSP_ASSERT_SAME(a_out_cause, $rose(out_valid), $past(in_valid && in_ready, 2), "spec from nothing")

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .flag_plus (out_rsp.flag_plus),
  .flag_space(out_rsp.flag_space),
  .precision (out_rsp.precision)
);

`default_nettype wire
